// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the fixed-latency memory queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FLMQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FLMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FLMQ_ASSERT(label, clk, rst, prop, msg)
`define FLMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/flmq_pkg.sv -----
// Package with the types, constants and helpers of the fixed-latency memory queue.
`default_nettype none
package flmq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYCLE_BITS = 32;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int LATENCY_BITS = 16;
   localparam int MAX_OUT_BITS = 5;
   localparam int CMP_BITS = (COUNT_BITS > MAX_OUT_BITS) ? COUNT_BITS : MAX_OUT_BITS;
   localparam logic [LATENCY_BITS-1:0] LATENCY_RESET = 16'd100;
   localparam logic [MAX_OUT_BITS-1:0] MAX_OUT_RESET = 5'd16;

   localparam int MSG_ID_BITS = 16;
   localparam int ADDR_BITS = 48;
   localparam int AGENT_BITS = 8;
   localparam int RSP_CYCLE_BITS = 32;
   localparam int TOTAL_BITS = 32;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 16;

   localparam int REQ_DATA_BITS = 72;
   localparam int REQ_USER_BITS = 2;
   localparam int RSP_DATA_BITS = 168;
   localparam int RSP_USER_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LATENCY,
      CSR_MAX_OUTSTANDING
   } csr_index_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RETIRE
   } state_type;

   typedef struct packed {
      logic                   valid;
      logic                   is_write;
      logic [MSG_ID_BITS-1:0] msg_id;
      logic [ADDR_BITS-1:0]   addr;
      logic [AGENT_BITS-1:0]  agent_id;
   } item_type;

   typedef struct packed {
      logic [CYCLE_BITS-1:0]  stamp;
      logic                   is_write;
      logic [MSG_ID_BITS-1:0] msg_id;
      logic [AGENT_BITS-1:0]  agent_id;
      logic [ADDR_BITS-1:0]   addr;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic                      req_accepted;
      logic                      resp_valid;
      logic                      write_retired;
      logic [MSG_ID_BITS-1:0]    resp_msg_id;
      logic [ADDR_BITS-1:0]      resp_addr;
      logic [AGENT_BITS-1:0]     resp_agent_id;
      logic [RSP_CYCLE_BITS-1:0] resp_cycle;
      logic [TOTAL_BITS-1:0]     reads_total;
      logic [TOTAL_BITS-1:0]     writes_total;
   } result_type;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/flmq_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module flmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/flmq_ctrl.sv -----
// Queue controller: accept, stamp, head retire check, pointers and counters.
`default_nettype none
`include "assert_macros.svh"
module flmq_ctrl import flmq_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_fire,
   input  wire item_type                item,
   input  wire logic [LATENCY_BITS-1:0] latency,
   input  wire logic [MAX_OUT_BITS-1:0] max_outstanding,
   input  wire logic                    out_free,
   output logic                         item_ready,
   output logic                         result_load,
   output result_type                   result,
   output logic                         ram_wr_en,
   output logic [PTR_BITS-1:0]          ram_wr_addr,
   output entry_type                    ram_wr_data,
   output logic [PTR_BITS-1:0]          ram_rd_addr,
   input  wire entry_type               ram_rd_data
);

   state_type               state_ff, state_in;
   logic [PTR_BITS-1:0]     head_ff, head_in;
   logic [PTR_BITS-1:0]     tail_ff, tail_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [CYCLE_BITS-1:0]   cycle_ff, cycle_in;
   logic [TOTAL_BITS-1:0]   reads_ff, reads_in;
   logic [TOTAL_BITS-1:0]   writes_ff, writes_in;
   logic                    accepted_ff, accepted_in;
   logic                    had_entry_ff, had_entry_in;
   logic                    room;
   logic [CYCLE_BITS-1:0]   age;
   logic                    retire;

   assign room = (CMP_BITS'(count_ff) < CMP_BITS'(max_outstanding)) &&
                 (count_ff < COUNT_BITS'(QUEUE_DEPTH));
   assign age = cycle_ff - ram_rd_data.stamp;
   assign retire = had_entry_ff && (age > CYCLE_BITS'(latency));

   assign ram_wr_addr = tail_ff;
   assign ram_rd_addr = head_ff;

   always_comb begin
      ram_wr_data.stamp = cycle_ff;
      ram_wr_data.is_write = item.is_write;
      ram_wr_data.msg_id = item.msg_id;
      ram_wr_data.agent_id = item.agent_id;
      ram_wr_data.addr = item.addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         cycle_ff <= '0;
         reads_ff <= '0;
         writes_ff <= '0;
         accepted_ff <= 1'b0;
         had_entry_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         cycle_ff <= cycle_in;
         reads_ff <= reads_in;
         writes_ff <= writes_in;
         accepted_ff <= accepted_in;
         had_entry_ff <= had_entry_in;
      end
   end

   // A new entry never sits at the head unless the queue was empty, so the
   // write at the tail and the read at the head never meet on a live entry.
   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      cycle_in = cycle_ff;
      reads_in = reads_ff;
      writes_in = writes_ff;
      accepted_in = accepted_ff;
      had_entry_in = had_entry_ff;
      item_ready = 1'b0;
      result_load = 1'b0;
      ram_wr_en = 1'b0;
      result = '0;
      unique case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_fire) begin
               accepted_in = item.valid && room;
               had_entry_in = (count_ff != '0);
               if (item.valid && room) begin
                  ram_wr_en = 1'b1;
                  tail_in = next_ptr(tail_ff);
                  count_in = count_ff + COUNT_BITS'(1);
               end
               state_in = ST_RETIRE;
            end
         end
         ST_RETIRE: begin
            if (out_free) begin
               result_load = 1'b1;
               result.req_accepted = accepted_ff;
               if (retire) begin
                  head_in = next_ptr(head_ff);
                  count_in = count_ff - COUNT_BITS'(1);
                  if (ram_rd_data.is_write) begin
                     writes_in = writes_ff + TOTAL_BITS'(1);
                     result.write_retired = 1'b1;
                  end else begin
                     reads_in = reads_ff + TOTAL_BITS'(1);
                     result.resp_valid = 1'b1;
                     result.resp_msg_id = ram_rd_data.msg_id;
                     result.resp_addr = ram_rd_data.addr;
                     result.resp_agent_id = ram_rd_data.agent_id;
                     result.resp_cycle = RSP_CYCLE_BITS'(cycle_ff);
                  end
               end
               result.reads_total = reads_in;
               result.writes_total = writes_in;
               cycle_in = cycle_ff + CYCLE_BITS'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `FLMQ_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_BITS'(QUEUE_DEPTH), "queue count above depth")
   `FLMQ_ASSERT(a_empty_ptrs, clock, reset, (count_ff != '0) || (head_ff == tail_ff), "empty queue with unequal pointers")
   `FLMQ_ASSERT_NEXT(a_cycle_step, clock, reset, result_load, cycle_ff == $past(cycle_ff) + CYCLE_BITS'(1), "cycle count did not advance once per request")
   `FLMQ_ASSERT_NEXT(a_head_hold, clock, reset, state_ff == ST_IDLE, $stable(head_ff), "head moved while no request was in flight")

endmodule
`default_nettype wire

// ----- hw/rtl/fixed_latency_memory_queue.sv -----
// Top level: one request per tick in, one result per tick out, queue held in a RAM.
// Latency: a result is registered on the clock edge after the edge that accepts its request,
// later only while the output register still holds an unaccepted result.
// A request is taken only after the previous result is loaded: the registered read of the queue
// RAM at the head pointer must finish before the head and counts update for the next request.
// Reset clears pointers, counts, cycle count and totals; latency resets to 100 and the
// outstanding limit to 16. The queue RAM is not cleared; only occupied entries are used.
`default_nettype none
module fixed_latency_memory_queue import flmq_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,  // msg_id[15:0], addr[63:16], agent_id[71:64]
   input  wire logic [REQ_USER_BITS-1:0]  req_tuser,  // valid[0], is_write[1]
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [RSP_DATA_BITS-1:0]  rsp_tdata,  // msg_id[15:0], addr[63:16],
                                                      // agent_id[71:64], cycle[103:72],
                                                      // reads_total[135:104],
                                                      // writes_total[167:136]
   output logic      [RSP_USER_BITS-1:0]  rsp_tuser,  // req_accepted[0], resp_valid[1],
                                                      // write_retired[2]
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [LATENCY_BITS-1:0]  latency_ff, latency_in;
   logic [MAX_OUT_BITS-1:0]  max_out_ff, max_out_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_result_ff;
   item_type                 item;
   logic                     item_ready;
   logic                     item_fire;
   logic                     out_free;
   logic                     result_load;
   result_type               result;
   logic                     ram_wr_en;
   logic [PTR_BITS-1:0]      ram_wr_addr;
   entry_type                ram_wr_data;
   logic [PTR_BITS-1:0]      ram_rd_addr;
   entry_type                ram_rd_data;
   logic [ENTRY_BITS-1:0]    ram_rd_bits;

   assign csr_ready = 1'b1;

   always_comb begin
      latency_in = latency_ff;
      max_out_in = max_out_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LATENCY: latency_in = csr_data[LATENCY_BITS-1:0];
            CSR_MAX_OUTSTANDING: max_out_in = csr_data[MAX_OUT_BITS-1:0];
            default: begin
               latency_in = latency_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latency_ff <= LATENCY_RESET;
         max_out_ff <= MAX_OUT_RESET;
      end else begin
         latency_ff <= latency_in;
         max_out_ff <= max_out_in;
      end
   end

   always_comb begin
      item.valid = req_tuser[0];
      item.is_write = req_tuser[1];
      item.msg_id = req_tdata[MSG_ID_BITS-1:0];
      item.addr = req_tdata[MSG_ID_BITS +: ADDR_BITS];
      item.agent_id = req_tdata[MSG_ID_BITS + ADDR_BITS +: AGENT_BITS];
   end

   assign req_tready = item_ready;
   assign item_fire = req_tvalid && item_ready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   flmq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .item_fire       (item_fire),
      .item            (item),
      .latency         (latency_ff),
      .max_outstanding (max_out_ff),
      .out_free        (out_free),
      .item_ready      (item_ready),
      .result_load     (result_load),
      .result          (result),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   flmq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ENTRY_BITS'(ram_wr_data)),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = entry_type'(ram_rd_bits);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_result_ff.writes_total, rsp_result_ff.reads_total,
                       rsp_result_ff.resp_cycle, rsp_result_ff.resp_agent_id,
                       rsp_result_ff.resp_addr, rsp_result_ff.resp_msg_id};
   assign rsp_tuser = {rsp_result_ff.write_retired, rsp_result_ff.resp_valid,
                       rsp_result_ff.req_accepted};

endmodule
`default_nettype wire

// ----- verif/fixed_latency_memory_queue_tb.sv -----
// Self-checking testbench for the fixed-latency memory queue: ticks in, one result per tick out.
`timescale 1ns / 100ps
module fixed_latency_memory_queue_tb;
   import flmq_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic [REQ_USER_BITS-1:0]  req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [RSP_USER_BITS-1:0]  rsp_tuser;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index = CSR_LATENCY;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   fixed_latency_memory_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   item_type   queued_ticks[$];
   result_type predicted_results[$];
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   bit          quiet_phase = 1'b0;
   bit          req_offering = 1'b0;
   bit          req_taken = 1'b0;

   // Shadow copy of the memory queue.
   logic [ADDR_BITS-1:0]    slot_addr   [QUEUE_DEPTH];
   logic                    slot_write  [QUEUE_DEPTH];
   logic [MSG_ID_BITS-1:0]  slot_msg    [QUEUE_DEPTH];
   logic [AGENT_BITS-1:0]   slot_agent  [QUEUE_DEPTH];
   logic [CYCLE_BITS-1:0]   slot_stamp  [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     head_slot = '0;
   logic [PTR_BITS-1:0]     tail_slot = '0;
   int unsigned             fill_level = 0;
   logic [CYCLE_BITS-1:0]   tick_count = '0;
   logic [TOTAL_BITS-1:0]   reads_done = '0;
   logic [TOTAL_BITS-1:0]   writes_done = '0;
   logic [LATENCY_BITS-1:0] cfg_latency = LATENCY_RESET;
   logic [MAX_OUT_BITS-1:0] cfg_max_outstanding = MAX_OUT_RESET;

   function automatic result_type memory_tick(input item_type req);
      result_type              res;
      int unsigned             limit;
      logic [CYCLE_BITS-1:0]   age;
      res = '0;
      limit = (cfg_max_outstanding > QUEUE_DEPTH) ? QUEUE_DEPTH : cfg_max_outstanding;
      if (req.valid && fill_level < limit) begin
         slot_addr[tail_slot] = req.addr;
         slot_write[tail_slot] = req.is_write;
         slot_msg[tail_slot] = req.msg_id;
         slot_agent[tail_slot] = req.agent_id;
         slot_stamp[tail_slot] = tick_count;
         tail_slot = tail_slot + 1'b1;
         fill_level++;
         res.req_accepted = 1'b1;
      end
      if (fill_level > 0) begin
         age = tick_count - slot_stamp[head_slot];
         if (age > CYCLE_BITS'(cfg_latency)) begin
            if (slot_write[head_slot]) begin
               writes_done = writes_done + 1'b1;
               res.write_retired = 1'b1;
            end else begin
               reads_done = reads_done + 1'b1;
               res.resp_valid = 1'b1;
               res.resp_msg_id = slot_msg[head_slot];
               res.resp_addr = slot_addr[head_slot];
               res.resp_agent_id = slot_agent[head_slot];
               res.resp_cycle = tick_count;
            end
            head_slot = head_slot + 1'b1;
            fill_level--;
         end
      end
      tick_count = tick_count + 1'b1;
      res.reads_total = reads_done;
      res.writes_total = writes_done;
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (quiet_phase || roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(3, 1);
      else if (roll < 97)
         return $urandom_range(12, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic item_type random_request(input int unsigned idle_pct);
      item_type req;
      req.valid = ($urandom_range(99) >= idle_pct);
      req.is_write = 1'($urandom_range(1));
      case ($urandom_range(9))
         0: req.msg_id = '0;
         1: req.msg_id = '1;
         default: req.msg_id = MSG_ID_BITS'($urandom);
      endcase
      case ($urandom_range(9))
         0: req.addr = '0;
         1: req.addr = '1;
         default: req.addr = ADDR_BITS'({$urandom, $urandom});
      endcase
      case ($urandom_range(9))
         0: req.agent_id = '0;
         1: req.agent_id = '1;
         default: req.agent_id = AGENT_BITS'($urandom);
      endcase
      return req;
   endfunction

   task automatic push_request(input logic valid, input logic is_write,
                               input logic [MSG_ID_BITS-1:0] msg_id,
                               input logic [ADDR_BITS-1:0] addr,
                               input logic [AGENT_BITS-1:0] agent_id);
      queued_ticks.push_back('{valid, is_write, msg_id, addr, agent_id});
   endtask

   task automatic drain();
      do @(negedge clock);
      while (queued_ticks.size() != 0 || req_offering || predicted_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (index)
         CSR_LATENCY: cfg_latency = value;
         CSR_MAX_OUTSTANDING: cfg_max_outstanding = value[MAX_OUT_BITS-1:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_BITS-1:0] latency_value,
                            input logic [CSR_DATA_BITS-1:0] max_value,
                            input int unsigned count, input int unsigned idle_pct);
      drain();
      write_csr(CSR_LATENCY, latency_value);
      write_csr(CSR_MAX_OUTSTANDING, max_value);
      quiet_phase = ($urandom_range(3) == 0);
      repeat (count) queued_ticks.push_back(random_request(idle_pct));
   endtask

   // Request driver.
   always @(negedge clock) begin
      int unsigned gap_left;
      item_type    current;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_offering && req_taken)
            req_offering = 1'b0;
         req_taken = 1'b0;
         if (!req_offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_ticks.size() > 0) begin
               current = queued_ticks.pop_front();
               req_offering = 1'b1;
               gap_left = pick_gap();
               req_tdata <= {current.agent_id, current.addr, current.msg_id};
               req_tuser <= {current.is_write, current.valid};
            end
         end
         req_tvalid <= req_offering;
      end
   end

   // Response acceptor, with one long hold-off while requests keep coming.
   always @(negedge clock) begin
      int unsigned stall_left;
      int unsigned hold_left;
      bit          long_hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         long_hold_done = 1'b0;
      end else begin
         if (!long_hold_done && results_seen >= 200 && queued_ticks.size() > 30) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted result.
   always @(posedge clock) begin
      item_type   req;
      result_type got;
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req.valid = req_tuser[0];
            req.is_write = req_tuser[1];
            req.msg_id = req_tdata[15:0];
            req.addr = req_tdata[63:16];
            req.agent_id = req_tdata[71:64];
            predicted_results.push_back(memory_tick(req));
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.req_accepted = rsp_tuser[0];
            got.resp_valid = rsp_tuser[1];
            got.write_retired = rsp_tuser[2];
            got.resp_msg_id = rsp_tdata[15:0];
            got.resp_addr = rsp_tdata[63:16];
            got.resp_agent_id = rsp_tdata[71:64];
            got.resp_cycle = rsp_tdata[103:72];
            got.reads_total = rsp_tdata[135:104];
            got.writes_total = rsp_tdata[167:136];
            if (predicted_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
            end else begin
               want = predicted_results.pop_front();
               check_field("req_accepted", 64'(want.req_accepted), 64'(got.req_accepted));
               check_field("resp_valid", 64'(want.resp_valid), 64'(got.resp_valid));
               check_field("write_retired", 64'(want.write_retired), 64'(got.write_retired));
               check_field("resp_msg_id", 64'(want.resp_msg_id), 64'(got.resp_msg_id));
               check_field("resp_addr", 64'(want.resp_addr), 64'(got.resp_addr));
               check_field("resp_agent_id", 64'(want.resp_agent_id), 64'(got.resp_agent_id));
               check_field("resp_cycle", 64'(want.resp_cycle), 64'(got.resp_cycle));
               check_field("reads_total", 64'(want.reads_total), 64'(got.reads_total));
               check_field("writes_total", 64'(want.writes_total), 64'(got.writes_total));
            end
         end
      end
   end

   always @(posedge clock) begin
      int unsigned idle_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fixed_latency_memory_queue_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: the queue fills to sixteen, then further requests are refused.
      push_request(1'b1, 1'b0, '0, '0, '0);
      push_request(1'b1, 1'b1, '1, '1, '1);
      push_request(1'b0, 1'b1, '1, '1, '1);
      for (int i = 0; i < 14; i++)
         push_request(1'b1, i[0], MSG_ID_BITS'(16'h1111 * i), ADDR_BITS'(i) << (3 * i),
                      AGENT_BITS'(8'h80 >> (i % 8)));
      push_request(1'b1, 1'b0, 16'h5555, 48'haaaa_aaaa_aaaa, 8'h55);
      push_request(1'b1, 1'b1, 16'haaaa, 48'h5555_5555_5555, 8'haa);

      // Zero latency with a limit above the depth drains the full queue on idle ticks.
      run_phase(16'd0, 16'd31, 20, 100);
      // A zero limit refuses every request.
      run_phase(16'd5, 16'd0, 6, 0);
      // The limit is lowered below the fill level; held entries still retire.
      run_phase(16'd300, 16'd16, 10, 0);
      run_phase(16'd0, 16'd2, 12, 0);

      run_phase(16'd0, 16'd1, 40, 20);
      run_phase(16'd1, 16'd16, 50, 30);
      run_phase(16'd5, 16'd3, 40, 30);
      run_phase(16'd17, 16'd8, 50, 40);
      run_phase(16'hffff, 16'd16, 30, 10);
      run_phase(16'd2, 16'd31, 50, 25);
      run_phase(16'd12, 16'hffe5, 50, 35);
      run_phase(16'd9, 16'd4, 50, 30);
      run_phase(16'd0, 16'd16, 60, 10);
      drain();

      if (mismatches == 0)
         $display("fixed_latency_memory_queue_tb: done, clean");
      else
         $display("fixed_latency_memory_queue_tb: done, errors");
      $finish;
   end

endmodule
